FILE: src/sbf_pkg.sv
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types and constants of the scaled blit with fill block: item
// structs, configuration image, queue command and register indexes.
// ----------------------------------------------------------------------------
package sbf_pkg;

  // sizes
  localparam int PIX_W             = 24;
  localparam int COORD_W           = 16;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 32;
  localparam int QUEUE_DEPTH       = 4;
  localparam int SRC_PITCH_DEFAULT = 256;
  localparam int SRC_DEPTH_DEFAULT = 65536;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_ORIGIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_SIZE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ORIGIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_SIZE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR  = 3'd6;

  // item function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] load_address;
    logic [PIX_W-1:0]   load_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             from_source;
    logic             row_end;
    logic             frame_end;
  } out_item_t;

  // live configuration
  typedef struct packed {
    logic        [COORD_W-1:0] area_w;
    logic        [COORD_W-1:0] area_h;
    logic signed [COORD_W-1:0] dst_x;
    logic signed [COORD_W-1:0] dst_y;
    logic        [COORD_W-1:0] dst_w;
    logic        [COORD_W-1:0] dst_h;
    logic        [COORD_W-1:0] src_x;
    logic        [COORD_W-1:0] src_y;
    logic        [COORD_W-1:0] src_w;
    logic        [COORD_W-1:0] src_h;
    logic        [PIX_W-1:0]   fill;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_FILL,
    CMD_SOURCE
  } cmd_kind_t;

  // command from the front part to the back part
  typedef struct packed {
    cmd_kind_t          kind;
    logic [COORD_W-1:0] load_address;
    logic [PIX_W-1:0]   load_pixel;
    logic [COORD_W-1:0] off_x;
    logic [COORD_W-1:0] off_y;
    logic               row_end;
    logic               frame_end;
  } cmd_t;

endpackage

FILE: src/sbf_front.sv
// ----------------------------------------------------------------------------
// sbf_front
// Accepts items, walks the area in raster order and classifies each render
// as fill or source pixel, handing a command on unless the area is empty.
// ----------------------------------------------------------------------------
module sbf_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_accept,
  input  sbf_pkg::in_item_t in_item,
  input  sbf_pkg::cfg_t    cfg,
  output logic             cmd_valid,
  output sbf_pkg::cmd_t    cmd
);

  localparam int CW = sbf_pkg::COORD_W;

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;

  logic              area_empty;
  logic signed [CW+1:0] dx_ext, dy_ext, ex_ext, ey_ext;
  logic [CW-1:0]     start_x, end_x, start_y, end_y;
  logic              in_rect;
  logic              row_end, frame_end;
  logic              is_render;

  // clamp a signed edge into [0, hi]
  function automatic logic [CW-1:0] clamp_edge(input logic signed [CW+1:0] v,
                                              input logic [CW-1:0] hi);
    logic [CW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({2'b00, hi})) begin
      res = hi;
    end else begin
      res = v[CW-1:0];
    end
    return res;
  endfunction

  // clip rectangle and classification
  always_comb begin
    area_empty = (cfg.area_w == '0) || (cfg.area_h == '0);
    dx_ext     = {{2{cfg.dst_x[CW-1]}}, cfg.dst_x};
    dy_ext     = {{2{cfg.dst_y[CW-1]}}, cfg.dst_y};
    ex_ext     = dx_ext + $signed({2'b00, cfg.dst_w});
    ey_ext     = dy_ext + $signed({2'b00, cfg.dst_h});
    start_x    = clamp_edge(dx_ext, cfg.area_w);
    end_x      = clamp_edge(ex_ext, cfg.area_w);
    start_y    = clamp_edge(dy_ext, cfg.area_h);
    end_y      = clamp_edge(ey_ext, cfg.area_h);
    in_rect    = (col_r >= start_x) && (col_r < end_x) &&
                 (row_r >= start_y) && (row_r < end_y);
    row_end    = col_r >= (cfg.area_w - CW'(1));
    frame_end  = row_end && (row_r >= (cfg.area_h - CW'(1)));
    is_render  = in_item.func == sbf_pkg::FUNC_RENDER;
  end

  // command toward the queue
  always_comb begin
    cmd_valid          = in_accept && (!is_render || !area_empty);
    cmd.kind           = !is_render ? sbf_pkg::CMD_LOAD :
                         (in_rect ? sbf_pkg::CMD_SOURCE : sbf_pkg::CMD_FILL);
    cmd.load_address   = in_item.load_address;
    cmd.load_pixel     = in_item.load_pixel;
    cmd.off_x          = col_r - cfg.dst_x;
    cmd.off_y          = row_r - cfg.dst_y;
    cmd.row_end        = row_end;
    cmd.frame_end      = frame_end;
  end

  // raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_accept && is_render) begin
      if (area_empty) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + CW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

FILE: src/sbf_queue.sv
// ----------------------------------------------------------------------------
// sbf_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module sbf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sbf_pkg::cmd_t push_data,
  input  logic          pop,
  output sbf_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  localparam int DEPTH = sbf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sbf_pkg::cmd_t    entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // flags and pointer update
  always_comb begin
    empty      = count_r == '0;
    full       = count_r == CNT_W'(DEPTH);
    head       = entries_r[rd_ptr_r];
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/sbf_back.sv
// ----------------------------------------------------------------------------
// sbf_back
// Carries out commands: writes loads into the source store, scales source
// coordinates with a shift-subtract divider, reads the store and fills the
// output register.
// ----------------------------------------------------------------------------
module sbf_back #(
  parameter int SRC_PITCH_PIXELS = sbf_pkg::SRC_PITCH_DEFAULT,
  parameter int SRC_STORE_DEPTH  = sbf_pkg::SRC_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sbf_pkg::cfg_t      cfg,
  input  sbf_pkg::cmd_t      q_head,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_valid,
  output sbf_pkg::out_item_t out_item
);

  localparam int CW     = sbf_pkg::COORD_W;
  localparam int PW     = sbf_pkg::PIX_W;
  localparam int ADDR_W = $clog2(SRC_STORE_DEPTH);
  localparam int STEP_W = $clog2(CW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_ADDR,
    S_READ,
    S_OUT
  } state_t;

  state_t             state_r;
  logic [CW-1:0]      off_x_r, off_y_r;
  logic [CW-1:0]      rem_x_r, rem_y_r;
  logic [CW-1:0]      quo_x_r, quo_y_r;
  logic [STEP_W-1:0]  step_r;
  logic [ADDR_W-1:0]  addr_r;
  logic               src_r, row_end_r, frame_end_r;
  logic               out_valid_r;
  sbf_pkg::out_item_t out_item_r;
  logic [PW-1:0]      rd_data_r;
  logic [PW-1:0]      mem [SRC_STORE_DEPTH];

  logic               mem_we, mem_re, slot_free;
  logic [CW:0]        sx, sy;
  logic [ADDR_W-1:0]  addr_nxt;
  logic [2*CW-1:0]    div_x_nxt, div_y_nxt;

  // one restoring division step: remainder in the high half, the dividend
  // shifts out and the quotient shifts in the low half
  function automatic logic [2*CW-1:0] div_step(input logic [CW-1:0] rem,
                                              input logic [CW-1:0] quo,
                                              input logic [CW-1:0] d);
    logic [CW:0] trial;
    logic        bit_q;
    trial = {rem, quo[CW-1]};
    bit_q = trial >= {1'b0, d};
    if (bit_q) begin
      trial = trial - {1'b0, d};
    end
    return {trial[CW-1:0], quo[CW-2:0], bit_q};
  endfunction

  // datapath and control strobes
  always_comb begin
    q_pop     = (state_r == S_IDLE) && !q_empty;
    mem_we    = q_pop && (q_head.kind == sbf_pkg::CMD_LOAD);
    mem_re    = state_r == S_READ;
    slot_free = !out_valid_r || out_pop;
    div_x_nxt = div_step(rem_x_r, quo_x_r, cfg.dst_w);
    div_y_nxt = div_step(rem_y_r, quo_y_r, cfg.dst_h);
    sx        = {1'b0, cfg.src_x} + {1'b0, quo_x_r};
    sy        = {1'b0, cfg.src_y} + {1'b0, quo_y_r};
    addr_nxt  = ADDR_W'(sy) * ADDR_W'(SRC_PITCH_PIXELS) + ADDR_W'(sx);
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a popped result leaves unless a new one replaces it
      if (out_pop && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            off_x_r     <= q_head.off_x;
            off_y_r     <= q_head.off_y;
            row_end_r   <= q_head.row_end;
            frame_end_r <= q_head.frame_end;
            unique case (q_head.kind)
              sbf_pkg::CMD_FILL: begin
                src_r   <= 1'b0;
                state_r <= S_OUT;
              end
              sbf_pkg::CMD_SOURCE: begin
                src_r   <= 1'b1;
                state_r <= S_MUL;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_MUL: begin
          {rem_x_r, quo_x_r} <= off_x_r * cfg.src_w;
          {rem_y_r, quo_y_r} <= off_y_r * cfg.src_h;
          step_r             <= STEP_W'(CW - 1);
          state_r            <= S_DIV;
        end
        S_DIV: begin
          {rem_x_r, quo_x_r} <= div_x_nxt;
          {rem_y_r, quo_y_r} <= div_y_nxt;
          step_r             <= step_r - STEP_W'(1);
          if (step_r == '0) begin
            state_r <= S_ADDR;
          end
        end
        S_ADDR: begin
          addr_r  <= addr_nxt;
          state_r <= S_READ;
        end
        S_READ: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (slot_free) begin
            out_item_r.out_pixel   <= src_r ? rd_data_r : cfg.fill;
            out_item_r.from_source <= src_r;
            out_item_r.row_end     <= row_end_r;
            out_item_r.frame_end   <= frame_end_r;
            out_valid_r            <= 1'b1;
            state_r                <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // source store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ADDR_W'(q_head.load_address)] <= q_head.load_pixel;
    end
    if (mem_re) begin
      rd_data_r <= mem[addr_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: src/scaled_blit_with_fill_core.sv
// A load passes the command queue and is written when the back part pops
// it; a fill pixel goes from the queue to the output register, a source
// pixel through S_MUL, the 16-step shift-subtract divider, S_ADDR, S_READ.
// One load a cycle while the back part idles; it takes no command mid-pixel.
// A 4-entry command queue lets input acceptance run ahead of the back part.
// Reset (synchronous, rst_n low) clears configuration, state, counters and queues.
// ----------------------------------------------------------------------------
// scaled_blit_with_fill_core
// Nearest-neighbour scaled blit with fill: loads a source store, then emits
// area pixels in raster order. SRC_STORE_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module scaled_blit_with_fill_core #(
  parameter int SRC_PITCH_PIXELS = sbf_pkg::SRC_PITCH_DEFAULT,
  parameter int SRC_STORE_DEPTH  = sbf_pkg::SRC_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              push,
  output logic                              full,
  input  sbf_pkg::in_item_t                 in_data,
  // result items
  output logic                              empty,
  input  logic                              pop,
  output sbf_pkg::out_item_t                out_data,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [sbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW = sbf_pkg::COORD_W;

  sbf_pkg::cfg_t      cfg_r;
  sbf_pkg::cmd_t      cmd, q_head;
  logic               cmd_valid, q_empty, q_full, q_pop;
  logic               in_accept, out_valid;

  // configuration registers; the area origin moves nothing that is emitted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbf_pkg::CFG_AREA_ORIGIN: begin
        end
        sbf_pkg::CFG_AREA_SIZE: begin
          cfg_r.area_w <= cfg_data[CW-1:0];
          cfg_r.area_h <= cfg_data[2*CW-1:CW];
        end
        sbf_pkg::CFG_DST_ORIGIN: begin
          cfg_r.dst_x <= $signed(cfg_data[CW-1:0]);
          cfg_r.dst_y <= $signed(cfg_data[2*CW-1:CW]);
        end
        sbf_pkg::CFG_DST_SIZE: begin
          cfg_r.dst_w <= cfg_data[CW-1:0];
          cfg_r.dst_h <= cfg_data[2*CW-1:CW];
        end
        sbf_pkg::CFG_SRC_ORIGIN: begin
          cfg_r.src_x <= cfg_data[CW-1:0];
          cfg_r.src_y <= cfg_data[2*CW-1:CW];
        end
        sbf_pkg::CFG_SRC_SIZE: begin
          cfg_r.src_w <= cfg_data[CW-1:0];
          cfg_r.src_h <= cfg_data[2*CW-1:CW];
        end
        sbf_pkg::CFG_FILL_COLOR: begin
          cfg_r.fill <= cfg_data[sbf_pkg::PIX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // handshakes
  assign in_accept = push && !q_full;
  assign full      = q_full;
  assign empty     = !out_valid;

  // front part: raster walk and classification
  sbf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_item   (in_data),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // command queue
  sbf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_valid),
    .push_data (cmd),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // back part: store, scaling and output
  sbf_back #(
    .SRC_PITCH_PIXELS (SRC_PITCH_PIXELS),
    .SRC_STORE_DEPTH  (SRC_STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (pop),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

`ifndef SYNTH
  // no result is offered right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result offered after reset");

  // the end of the area is always the end of a row
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.row_end || !out_data.frame_end))
    else $error("frame end without row end");

  // a full queue that is not drained stays full, so nothing was pushed over
  a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !q_pop) |=> q_full)
    else $error("command queue changed while full and not drained");
`endif

endmodule

FILE: bench/tb_scaled_blit_with_fill_core.sv
// ----------------------------------------------------------------------------
// tb_scaled_blit_with_fill_core
// Self-checking bench for the scaled blit with fill core. Loads and renders
// go in through a push/full queue and pixels come back through empty/pop.
// A predictor in the bench tracks the source store, the raster position and
// the register image. Each popped pixel is checked against the oldest
// expected one. A short directed part covers clipping, zero sizes, address
// wrap, an empty area and a shrinking area. Random phases follow under new
// register settings, with random idling on both sides in the first six.
// ----------------------------------------------------------------------------
module tb_scaled_blit_with_fill_core;

  localparam int PITCH        = sbf_pkg::SRC_PITCH_DEFAULT;
  localparam int STORE_DEPTH  = sbf_pkg::SRC_DEPTH_DEFAULT;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 5000;
  localparam int SHOW_LIMIT   = 10;
  localparam int PHASES       = 9;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           push      = 1'b0;
  logic                           full;
  sbf_pkg::in_item_t              in_data   = '0;
  logic                           empty;
  logic                           pop       = 1'b0;
  sbf_pkg::out_item_t             out_data;
  logic                           cfg_we    = 1'b0;
  logic [sbf_pkg::CFG_IDX_W-1:0]  cfg_index = sbf_pkg::CFG_AREA_ORIGIN;
  logic [sbf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // register image, source store and raster position of the predictor
  logic [sbf_pkg::CFG_DATA_W-1:0] blit_regs [sbf_pkg::CFG_AREA_ORIGIN:sbf_pkg::CFG_FILL_COLOR];
  logic [sbf_pkg::PIX_W-1:0]      src_mem [0:STORE_DEPTH-1];
  logic [sbf_pkg::COORD_W-1:0]    pix_col = '0;
  logic [sbf_pkg::COORD_W-1:0]    pix_row = '0;

  // stimulus side: its own raster position and which entries hold a pixel
  bit                             loaded [0:STORE_DEPTH-1];
  logic [sbf_pkg::COORD_W-1:0]    gen_col = '0;
  logic [sbf_pkg::COORD_W-1:0]    gen_row = '0;

  sbf_pkg::in_item_t              pending_items [$];
  sbf_pkg::out_item_t             expected_pixels [$];
  int                             send_idle_pct = 17;
  int                             recv_idle_pct = 51;
  int                             fail_count    = 0;
  int                             stall_cycles  = 0;

  scaled_blit_with_fill_core #(
    .SRC_PITCH_PIXELS(PITCH),
    .SRC_STORE_DEPTH (STORE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int clip_to_area(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // source address of the pixel at col/row, 0 when it falls outside the clipped rectangle
  function automatic bit source_hit(input logic [sbf_pkg::COORD_W-1:0] col,
                                    input logic [sbf_pkg::COORD_W-1:0] row,
                                    output logic [sbf_pkg::COORD_W-1:0] addr);
    int     aw, ah, dx, dy, dw, dh, c, r;
    longint sw, sh, sx, sy;
    aw = blit_regs[sbf_pkg::CFG_AREA_SIZE][15:0];
    ah = blit_regs[sbf_pkg::CFG_AREA_SIZE][31:16];
    dx = $signed(blit_regs[sbf_pkg::CFG_DST_ORIGIN][15:0]);
    dy = $signed(blit_regs[sbf_pkg::CFG_DST_ORIGIN][31:16]);
    dw = blit_regs[sbf_pkg::CFG_DST_SIZE][15:0];
    dh = blit_regs[sbf_pkg::CFG_DST_SIZE][31:16];
    sw = blit_regs[sbf_pkg::CFG_SRC_SIZE][15:0];
    sh = blit_regs[sbf_pkg::CFG_SRC_SIZE][31:16];
    c = col;
    r = row;
    addr = '0;
    if (c < clip_to_area(dx, aw) || c >= clip_to_area(dx + dw, aw) ||
        r < clip_to_area(dy, ah) || r >= clip_to_area(dy + dh, ah)) begin
      return 1'b0;
    end
    sx = longint'(blit_regs[sbf_pkg::CFG_SRC_ORIGIN][15:0]) + (longint'(c - dx) * sw) / dw;
    sy = longint'(blit_regs[sbf_pkg::CFG_SRC_ORIGIN][31:16]) + (longint'(r - dy) * sh) / dh;
    addr = sbf_pkg::COORD_W'((sy * PITCH + sx) % STORE_DEPTH);
    return 1'b1;
  endfunction

  // raster advance; 0 when the area is empty and no pixel comes out
  function automatic bit step_position(inout logic [sbf_pkg::COORD_W-1:0] col,
                                       inout logic [sbf_pkg::COORD_W-1:0] row,
                                       output bit rend, output bit fend);
    int aw, ah;
    aw = blit_regs[sbf_pkg::CFG_AREA_SIZE][15:0];
    ah = blit_regs[sbf_pkg::CFG_AREA_SIZE][31:16];
    rend = 1'b0;
    fend = 1'b0;
    if (aw == 0 || ah == 0) begin
      col = '0;
      row = '0;
      return 1'b0;
    end
    rend = int'(col) >= aw - 1;
    fend = rend && int'(row) >= ah - 1;
    if (rend) begin
      col = '0;
      row = fend ? '0 : row + 1'b1;
    end else begin
      col = col + 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic queue_load(input logic [sbf_pkg::COORD_W-1:0] addr,
                            input logic [sbf_pkg::PIX_W-1:0] pixel);
    sbf_pkg::in_item_t item;
    item.func         = sbf_pkg::FUNC_LOAD;
    item.load_address = addr;
    item.load_pixel   = pixel;
    loaded[addr] = 1'b1;
    pending_items.push_back(item);
  endtask

  // renders; a source entry about to be read for the first time gets loaded first
  task automatic queue_renders(input int count);
    logic [sbf_pkg::COORD_W-1:0] addr;
    bit                          rend, fend;
    sbf_pkg::in_item_t           item;
    repeat (count) begin
      if (source_hit(gen_col, gen_row, addr) && !loaded[addr]) begin
        queue_load(addr, sbf_pkg::PIX_W'($urandom));
      end
      void'(step_position(gen_col, gen_row, rend, fend));
      item.func         = sbf_pkg::FUNC_RENDER;
      item.load_address = sbf_pkg::COORD_W'($urandom);
      item.load_pixel   = sbf_pkg::PIX_W'($urandom);
      pending_items.push_back(item);
    end
  endtask

  // hold off until every item is in and every pixel is out, then let the back end settle
  task automatic wait_drained();
    while (pending_items.size() > 0 || push || expected_pixels.size() > 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs();
    for (int i = sbf_pkg::CFG_AREA_ORIGIN; i <= sbf_pkg::CFG_FILL_COLOR; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= sbf_pkg::CFG_IDX_W'(i);
      cfg_data  <= blit_regs[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // driver: presents pending items and predicts each accepted one
  always @(posedge clk) begin : drive_items
    logic [sbf_pkg::COORD_W-1:0] addr;
    sbf_pkg::out_item_t          px;
    bit                          hit, rend, fend;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        if (in_data.func == sbf_pkg::FUNC_LOAD) begin
          src_mem[in_data.load_address] = in_data.load_pixel;
        end else begin
          hit = source_hit(pix_col, pix_row, addr);
          px.out_pixel   = hit ? src_mem[addr]
                               : blit_regs[sbf_pkg::CFG_FILL_COLOR][sbf_pkg::PIX_W-1:0];
          px.from_source = hit;
          if (step_position(pix_col, pix_row, rend, fend)) begin
            px.row_end   = rend;
            px.frame_end = fend;
            expected_pixels.push_back(px);
          end
        end
      end
      if (!push || !full) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_items.pop_front();
          push    <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: pops pixels and checks them against the oldest expected one
  always @(posedge clk) begin : check_pixels
    sbf_pkg::out_item_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT) begin
            $display("unexpected pixel: got pixel=%h src=%b row_end=%b frame_end=%b",
                     out_data.out_pixel, out_data.from_source, out_data.row_end,
                     out_data.frame_end);
          end
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.out_pixel !== want.out_pixel ||
              out_data.from_source !== want.from_source ||
              out_data.row_end !== want.row_end ||
              out_data.frame_end !== want.frame_end) begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT) begin
              $display("pixel mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
                       want.out_pixel, want.from_source, want.row_end, want.frame_end,
                       out_data.out_pixel, out_data.from_source, out_data.row_end,
                       out_data.frame_end);
            end
          end
        end
      end
      pop <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("scaled_blit_with_fill_core test failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int aw, ah, sw, sh;
    for (int i = sbf_pkg::CFG_AREA_ORIGIN; i <= sbf_pkg::CFG_FILL_COLOR; i++) begin
      blit_regs[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extreme load addresses and pixels, then a render into the empty reset area
    queue_load('0, '1);
    queue_load('1, '0);
    queue_renders(1);
    wait_drained();

    // destination hangs over the left, bottom and right edges; source wraps the store
    blit_regs[sbf_pkg::CFG_AREA_ORIGIN] = 32'hFFFF_FFFF;
    blit_regs[sbf_pkg::CFG_AREA_SIZE]   = {16'd2, 16'd3};
    blit_regs[sbf_pkg::CFG_DST_ORIGIN]  = {16'd1, 16'hFFFF};
    blit_regs[sbf_pkg::CFG_DST_SIZE]    = {16'd5, 16'd6};
    blit_regs[sbf_pkg::CFG_SRC_ORIGIN]  = 32'hFFFF_FFFE;
    blit_regs[sbf_pkg::CFG_SRC_SIZE]    = {16'd2, 16'd3};
    blit_regs[sbf_pkg::CFG_FILL_COLOR]  = 32'hFF00_0000;
    write_regs();
    queue_renders(6);
    wait_drained();

    // zero destination and source size: all fill; stop mid-frame
    blit_regs[sbf_pkg::CFG_DST_SIZE]   = '0;
    blit_regs[sbf_pkg::CFG_SRC_SIZE]   = '0;
    blit_regs[sbf_pkg::CFG_FILL_COLOR] = 32'h00FF_FFFF;
    write_regs();
    queue_renders(4);
    wait_drained();

    // area shrinks under the counters, then becomes empty
    blit_regs[sbf_pkg::CFG_AREA_SIZE] = {16'd1, 16'd2};
    write_regs();
    queue_renders(2);
    wait_drained();
    blit_regs[sbf_pkg::CFG_AREA_SIZE] = {16'd0, 16'd2};
    write_regs();
    queue_renders(1);
    wait_drained();

    // zero source size: every inside pixel reads the source origin
    blit_regs[sbf_pkg::CFG_AREA_SIZE]  = {16'd2, 16'd2};
    blit_regs[sbf_pkg::CFG_DST_ORIGIN] = '0;
    blit_regs[sbf_pkg::CFG_DST_SIZE]   = {16'd2, 16'd2};
    blit_regs[sbf_pkg::CFG_SRC_ORIGIN] = {16'd7, 16'd5};
    write_regs();
    queue_renders(4);

    // random phases, each under fresh register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph == 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 17;
      end
      if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 4 || ph == 7) begin
        // widest sizes with the most negative origin, or a far-right origin in a 1x1 area
        blit_regs[sbf_pkg::CFG_AREA_ORIGIN] = (ph == 4) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        blit_regs[sbf_pkg::CFG_AREA_SIZE]   = (ph == 4) ? 32'hFFFF_FFFF : {16'd1, 16'd1};
        blit_regs[sbf_pkg::CFG_DST_ORIGIN]  = (ph == 4) ? 32'h8000_8000 : 32'h7FFF_7FFF;
        blit_regs[sbf_pkg::CFG_DST_SIZE]    = 32'hFFFF_FFFF;
        blit_regs[sbf_pkg::CFG_SRC_ORIGIN]  = 32'hFFFF_FFFF;
        blit_regs[sbf_pkg::CFG_SRC_SIZE]    = 32'hFFFF_FFFF;
        blit_regs[sbf_pkg::CFG_FILL_COLOR]  = 32'h00FF_FFFF;
      end else begin
        aw = $urandom_range(8, 1);
        ah = $urandom_range(5, 1);
        if ($urandom_range(11) == 0) begin
          aw = 0;
        end
        sw = ($urandom_range(6) == 0) ? 16'hFFFF : $urandom_range(20);
        sh = ($urandom_range(6) == 0) ? 16'hFFFF : $urandom_range(20);
        blit_regs[sbf_pkg::CFG_AREA_ORIGIN] = $urandom;
        blit_regs[sbf_pkg::CFG_AREA_SIZE]   = {16'(ah), 16'(aw)};
        blit_regs[sbf_pkg::CFG_DST_ORIGIN]  = {16'($urandom_range(14) - 4),
                                               16'($urandom_range(14) - 4)};
        blit_regs[sbf_pkg::CFG_DST_SIZE]    = {16'($urandom_range(10)),
                                               16'($urandom_range(12))};
        blit_regs[sbf_pkg::CFG_SRC_ORIGIN]  = $urandom_range(1) ? $urandom
                                              : {16'($urandom_range(255)),
                                                 16'($urandom_range(255))};
        blit_regs[sbf_pkg::CFG_SRC_SIZE]    = {16'(sh), 16'(sw)};
        blit_regs[sbf_pkg::CFG_FILL_COLOR]  = $urandom;
      end
      write_regs();
      // mostly renders, with stray loads anywhere in the store
      for (int n = $urandom_range(60, 40); n > 0; n--) begin
        if ($urandom_range(3) == 0) begin
          queue_load(sbf_pkg::COORD_W'($urandom), sbf_pkg::PIX_W'($urandom));
        end else begin
          queue_renders(1);
        end
      end
    end

    wait_drained();
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("scaled_blit_with_fill_core test passed");
    end else begin
      $display("scaled_blit_with_fill_core test failed");
    end
    $finish;
  end

endmodule
